FILE: hdl/ebm_pkg.sv
// ----------------------------------------------------------------------------
// ebm_pkg
// Shared types and constants of the extent bitmap marker.
// ----------------------------------------------------------------------------
package ebm_pkg;

  localparam int MAP_BLOCKS = 65536;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = MAP_BLOCKS / WORD_BITS;
  localparam int ADDR_W     = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);

  localparam int START_W  = 16;
  localparam int LENGTH_W = 17;
  localparam int DEV_W    = 17;
  localparam int RUNS_W   = 16;
  localparam int BLOCKS_W = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_BLOCKS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_OVERLAPS = 1'd1;

  localparam logic [DEV_W-1:0] DEVICE_BLOCKS_RST = DEV_W'(65536);

  typedef enum logic [1:0] {
    CMD_BEGIN,
    CMD_SKIP,
    CMD_WALK
  } cmd_kind_e;

  typedef struct packed {
    logic                action;
    logic [START_W-1:0]  extent_start;
    logic [LENGTH_W-1:0] extent_length;
  } in_word_t;

  typedef struct packed {
    logic [RUNS_W-1:0]   overlap_runs;
    logic [BLOCKS_W-1:0] overlap_blocks;
    logic [START_W-1:0]  first_overlap_block;
    logic                error_seen;
  } out_word_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ADDR_W-1:0] first_word;
    logic [ADDR_W-1:0] last_word;
    logic [BIT_W-1:0]  lo_bit;
    logic [BIT_W-1:0]  hi_bit;
  } cmd_t;

  typedef struct packed {
    logic cmd_pop;
    logic init_busy;
  } bk_status_t;

endpackage

FILE: hdl/extent_bitmap_marker.sv
// ----------------------------------------------------------------------------
// extent_bitmap_marker
// Block usage bitmap with per-extent overlap reporting.
// ----------------------------------------------------------------------------
// input words enter through push/full, result words leave through empty/pop,
// one result word per input word, in order.
// configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 device_blocks, 1 report_overlaps); write only while the block is idle.
// the map lives in a 2048 x 32 bit RAM, walked one word per cycle.
// extent word: IDLE, READ, then one MOD step per word spanned, then DONE;
// hole or empty extent: IDLE straight to DONE.
// begin word: a clearing sweep of all 2048 map words, then the result.
// after reset the map is swept once with full held high.
// two commands queue ahead of the walker and two results queue behind it;
// when the receiver stalls the result queue fills, then the walker waits,
// then the command queue fills and full rises.
// ----------------------------------------------------------------------------
module extent_bitmap_marker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  ebm_pkg::in_word_t               in_word_i,
  output logic                            empty,
  input  logic                            pop,
  output ebm_pkg::out_word_t              out_word_o,
  input  logic                            cfg_we_i,
  input  logic [ebm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ebm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ebm_pkg::*;

  logic [DEV_W-1:0] dev_q;
  logic             rep_q;
  logic             cmd_valid;
  cmd_t             cmd;
  bk_status_t       status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= DEVICE_BLOCKS_RST;
      rep_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEVICE_BLOCKS:   dev_q <= cfg_data_i[DEV_W-1:0];
        REG_REPORT_OVERLAPS: rep_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ebm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .in_word_i       (in_word_i),
    .device_blocks_i (dev_q),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .status_i        (status)
  );

  ebm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .status_o    (status),
    .report_i    (rep_q),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: hdl/ebm_ram.sv
// ----------------------------------------------------------------------------
// ebm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ebm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/ebm_front.sv
// ----------------------------------------------------------------------------
// ebm_front
// Accepts input words, clips each extent to the device and queues commands.
// ----------------------------------------------------------------------------
module ebm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  ebm_pkg::in_word_t          in_word_i,
  input  logic [ebm_pkg::DEV_W-1:0]  device_blocks_i,
  output logic                       cmd_valid_o,
  output ebm_pkg::cmd_t              cmd_o,
  input  ebm_pkg::bk_status_t        status_i
);
  import ebm_pkg::*;

  localparam int END_W = LENGTH_W + 1;

  cmd_t                 q_q [2];
  logic                 wp_q, rp_q;
  logic [1:0]           cnt_q;
  logic                 accept;
  logic [DEV_W-1:0]     lim;
  logic [END_W-1:0]     end_full;
  logic [DEV_W-1:0]     eff_end;
  logic [DEV_W-1:0]     last_blk;
  cmd_t                 cmd_new;

  assign full        = (cnt_q == 2'd2) || status_i.init_busy;
  assign accept      = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rp_q];

  // clip the extent to the device and to the map
  always_comb begin
    lim      = (device_blocks_i < DEV_W'(MAP_BLOCKS)) ? device_blocks_i : DEV_W'(MAP_BLOCKS);
    end_full = END_W'(in_word_i.extent_start) + END_W'(in_word_i.extent_length);
    eff_end  = (end_full < END_W'(lim)) ? end_full[DEV_W-1:0] : lim;
    last_blk = eff_end - DEV_W'(1);
    cmd_new.first_word = in_word_i.extent_start[BIT_W +: ADDR_W];
    cmd_new.lo_bit     = in_word_i.extent_start[BIT_W-1:0];
    cmd_new.last_word  = last_blk[BIT_W +: ADDR_W];
    cmd_new.hi_bit     = last_blk[BIT_W-1:0];
    if (!in_word_i.action) begin
      cmd_new.kind = CMD_BEGIN;
    end else if (in_word_i.extent_start == '0) begin
      cmd_new.kind = CMD_SKIP;
    end else if (DEV_W'(in_word_i.extent_start) < eff_end) begin
      cmd_new.kind = CMD_WALK;
    end else begin
      cmd_new.kind = CMD_SKIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (accept) begin
        wp_q <= ~wp_q;
      end
      if (status_i.cmd_pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(accept) - 2'(status_i.cmd_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_q[wp_q] <= cmd_new;
    end
  end

endmodule

FILE: hdl/ebm_back.sv
// ----------------------------------------------------------------------------
// ebm_back
// Clears or walks the usage map one word per cycle, counts overlaps, queues results.
// ----------------------------------------------------------------------------
module ebm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  ebm_pkg::cmd_t         cmd_i,
  output ebm_pkg::bk_status_t   status_o,
  input  logic                  report_i,
  output logic                  empty,
  input  logic                  pop,
  output ebm_pkg::out_word_t    out_word_o
);
  import ebm_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [BIT_W-1:0]     BIT_MAX  = BIT_W'(WORD_BITS - 1);
  localparam logic [ADDR_W-1:0]    ADDR_MAX = ADDR_W'(MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0] ONES     = '1;

  logic [2:0]           st_q, st_d;
  logic                 init_q, init_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  logic                 err_q, err_d;
  logic [ADDR_W-1:0]    word_q, word_d;
  logic [ADDR_W-1:0]    first_w_q, first_w_d;
  logic [ADDR_W-1:0]    last_w_q, last_w_d;
  logic [BIT_W-1:0]     lo_q, lo_d;
  logic [BIT_W-1:0]     hi_q, hi_d;
  logic [RUNS_W-1:0]    runs_q, runs_d;
  logic [BLOCKS_W-1:0]  blocks_q, blocks_d;
  logic [START_W-1:0]   first_q, first_d;
  logic                 carry_q, carry_d;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [BIT_W-1:0]     lo_eff, hi_eff, low_idx;
  logic [WORD_BITS-1:0] mask, ov, starts;

  out_word_t            rq_q [2];
  logic                 rwp_q, rrp_q;
  logic [1:0]           rcnt_q;
  logic                 res_full, res_push, res_pop;
  out_word_t            res_new;
  logic                 err_new;

  ebm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // word mask and overlap bits
  always_comb begin
    lo_eff = (word_q == first_w_q) ? lo_q : '0;
    hi_eff = (word_q == last_w_q) ? hi_q : BIT_MAX;
    mask   = (ONES << lo_eff) & (ONES >> (BIT_MAX - hi_eff));
    ov     = ram_rdata & mask;
    starts = ov & ~{ov[WORD_BITS-2:0], carry_q};
    low_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (ov[i]) begin
        low_idx = BIT_W'(i);
      end
    end
  end

  assign res_full = (rcnt_q == 2'd2);
  assign res_pop  = pop && !empty;
  assign empty    = (rcnt_q == 2'd0);
  assign out_word_o = rq_q[rrp_q];

  always_comb begin
    err_new = err_q | (report_i && (blocks_q != '0));
    res_new.overlap_runs        = report_i ? runs_q : '0;
    res_new.overlap_blocks      = report_i ? blocks_q : '0;
    res_new.first_overlap_block = report_i ? first_q : '0;
    res_new.error_seen          = err_new;
  end

  always_comb begin
    st_d      = st_q;
    init_d    = init_q;
    clr_d     = clr_q;
    err_d     = err_q;
    word_d    = word_q;
    first_w_d = first_w_q;
    last_w_d  = last_w_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    runs_d    = runs_q;
    blocks_d  = blocks_q;
    first_d   = first_q;
    carry_d   = carry_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = word_q;
    ram_raddr = word_q;
    ram_wdata = ram_rdata | mask;
    res_push  = 1'b0;
    status_o.cmd_pop   = 1'b0;
    status_o.init_busy = init_q;
    unique case (st_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == '0) ? WORD_BITS'(1) : '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_MAX) begin
          init_d = 1'b0;
          st_d   = init_q ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          status_o.cmd_pop = 1'b1;
          runs_d    = '0;
          blocks_d  = '0;
          first_d   = '0;
          carry_d   = 1'b0;
          word_d    = cmd_i.first_word;
          first_w_d = cmd_i.first_word;
          last_w_d  = cmd_i.last_word;
          lo_d      = cmd_i.lo_bit;
          hi_d      = cmd_i.hi_bit;
          unique case (cmd_i.kind)
            CMD_BEGIN: begin
              err_d = 1'b0;
              clr_d = '0;
              st_d  = ST_CLEAR;
            end
            CMD_WALK: st_d = ST_READ;
            default:  st_d = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
        st_d   = ST_MOD;
      end
      ST_MOD: begin
        ram_we    = 1'b1;
        ram_raddr = word_q + ADDR_W'(1);
        ram_re    = (word_q != last_w_q);
        runs_d    = runs_q + RUNS_W'($countones(starts));
        blocks_d  = blocks_q + BLOCKS_W'($countones(ov));
        carry_d   = ov[WORD_BITS-1];
        if (blocks_q == '0 && ov != '0) begin
          first_d = {word_q, low_idx};
        end
        if (word_q == last_w_q) begin
          st_d = ST_DONE;
        end else begin
          word_d = word_q + ADDR_W'(1);
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push = 1'b1;
          err_d    = err_new;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_CLEAR;
      init_q <= 1'b1;
      clr_q  <= '0;
      err_q  <= 1'b0;
      rwp_q  <= 1'b0;
      rrp_q  <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      st_q   <= st_d;
      init_q <= init_d;
      clr_q  <= clr_d;
      err_q  <= err_d;
      if (res_push) begin
        rwp_q <= ~rwp_q;
      end
      if (res_pop) begin
        rrp_q <= ~rrp_q;
      end
      rcnt_q <= rcnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    first_w_q <= first_w_d;
    last_w_q  <= last_w_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    runs_q    <= runs_d;
    blocks_q  <= blocks_d;
    first_q   <= first_d;
    carry_q   <= carry_d;
    if (res_push) begin
      rq_q[rwp_q] <= res_new;
    end
  end

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MOD) |-> (word_q <= last_w_q))
    else $error("walk passed last word");

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (rcnt_q != 2'd2))
    else $error("result queue overflow");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && report_i && (blocks_q != '0)) |=> err_q)
    else $error("overlap did not set error flag");

  a_init_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !status_o.cmd_pop)
    else $error("command taken during init clear");

endmodule
